@@ rtl/core/spq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue, its cells and
// its channel interfaces.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned ACT_W = 2;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned PRI_W = 32;
  localparam int unsigned STS_W = 3;
  localparam int unsigned OCC_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_ENQ  = 2'd0,
    ACT_DEQ  = 2'd1,
    ACT_LIST = 2'd2
  } action_e;

  typedef enum logic [STS_W-1:0] {
    ST_ENQ   = 3'd0,
    ST_OVF   = 3'd1,
    ST_DEQ   = 3'd2,
    ST_UNF   = 3'd3,
    ST_LIST  = 3'd4,
    ST_EMPTY = 3'd5
  } status_e;

  // operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_POP  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic signed [PRI_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    cell_op_e                op;
    logic signed [VAL_W-1:0] value;
    logic signed [PRI_W-1:0] prio;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/core/spq_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spq channel interfaces
// Valid/ready channels carrying request items into and result items out of
// the sorted priority queue.
// ----------------------------------------------------------------------------
interface spq_in_if
  import spq_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [VAL_W-1:0] item_value;
  logic signed [PRI_W-1:0] item_priority;

  modport source (output valid, action, item_value, item_priority, input ready);
  modport sink   (input valid, action, item_value, item_priority, output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [STS_W-1:0]        status;
  logic signed [VAL_W-1:0] out_value;
  logic signed [PRI_W-1:0] out_priority;
  logic [OCC_W-1:0]        occupancy;
  logic                    last;

  modport source (output valid, status, out_value, out_priority, occupancy, last,
                  input ready);
  modport sink   (input valid, status, out_value, out_priority, occupancy, last,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/core/spq_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry and updates it from the new
// item, its upper neighbour, its lower neighbour or the head.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire entry_t     prev_i,
  input  wire logic       prev_ge_i,
  input  wire entry_t     next_i,
  input  wire entry_t     head_i,
  output entry_t          entry_o,
  output logic            ge_o
);

  entry_t entry_q, entry_d;

  // entry stays ahead of the new item: priority greater or equal
  assign ge_o = entry_q.valid && (entry_q.prio >= ctrl_i.prio);

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      OP_INS: begin
        if (!ge_o) begin
          if (prev_ge_i) begin
            entry_d.valid = 1'b1;
            entry_d.value = ctrl_i.value;
            entry_d.prio  = ctrl_i.prio;
          end else begin
            entry_d = prev_i;
          end
        end
      end
      OP_POP: entry_d = next_i;
      OP_ROT: begin
        // tail wraps round to the head
        if (entry_q.valid) begin
          entry_d = next_i.valid ? next_i : head_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

@@ rtl/core/sorted_priority_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a chain of cells, descending
// priority, first in first out among equal priorities.
// ----------------------------------------------------------------------------
// usage
//   in_i  : request items (action, item_value, item_priority); action 0
//           enqueues, 1 dequeues, 2 lists, 3 is taken and dropped silently
//   out_o : result items (status, out_value, out_priority, occupancy, last)
//   the result sits in the output register the cycle after the request is
//   taken, and a new request is taken in the same cycle as the previous
//   result leaves, so a steady stream of enqueues and dequeues runs at one
//   item per cycle while the receiver does not stall
//   a list of n entries gives n results, one per cycle while the receiver
//   does not stall, the chain rotating by one cell per result; requests are
//   held off until the final listed result is in the output register
//   the insertion compare is done in parallel by every cell against the
//   broadcast priority, so the rate does not depend on DEPTH
//   reset empties the queue at once (every cell entry is cleared) and drops
//   any pending result; no clearing sweep is needed
//   a stalled receiver freezes the output register and, through ready,
//   the request side
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // chain of cells
  entry_t     cell_entry [DEPTH];
  logic       cell_ge    [DEPTH];
  cell_ctrl_t ctrl;

  // bookkeeping
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] list_rem_q, list_rem_d;
  logic             list_busy;
  logic             slot_free;
  logic             in_acc;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic                    out_load;
  status_e                 sts_d;
  logic signed [VAL_W-1:0] val_d;
  logic signed [PRI_W-1:0] pri_d;
  logic                    last_d;
  logic [STS_W-1:0]        sts_q;
  logic signed [VAL_W-1:0] val_q;
  logic signed [PRI_W-1:0] pri_q;
  logic [OCC_W-1:0]        occ_q;
  logic                    last_q;

  assign list_busy  = (list_rem_q != '0);
  assign slot_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = !list_busy && slot_free;
  assign in_acc     = in_i.valid && in_i.ready;

  // request decode and list sequencing
  always_comb begin
    ctrl.op    = OP_HOLD;
    ctrl.value = in_i.item_value;
    ctrl.prio  = in_i.item_priority;
    count_d    = count_q;
    list_rem_d = list_rem_q;
    out_load   = 1'b0;
    sts_d      = ST_ENQ;
    val_d      = '0;
    pri_d      = '0;
    last_d     = 1'b1;
    if (in_acc) begin
      case (in_i.action)
        ACT_ENQ: begin
          out_load = 1'b1;
          if (count_q == CNT_W'(DEPTH)) begin
            sts_d = ST_OVF;
          end else begin
            ctrl.op = OP_INS;
            count_d = count_q + 1'b1;
            sts_d   = ST_ENQ;
          end
        end
        ACT_DEQ: begin
          out_load = 1'b1;
          if (count_q == '0) begin
            sts_d = ST_UNF;
          end else begin
            ctrl.op = OP_POP;
            count_d = count_q - 1'b1;
            sts_d   = ST_DEQ;
            val_d   = cell_entry[0].value;
            pri_d   = cell_entry[0].prio;
          end
        end
        ACT_LIST: begin
          out_load = 1'b1;
          if (count_q == '0) begin
            sts_d = ST_EMPTY;
          end else begin
            ctrl.op    = OP_ROT;
            list_rem_d = count_q - 1'b1;
            sts_d      = ST_LIST;
            val_d      = cell_entry[0].value;
            pri_d      = cell_entry[0].prio;
            last_d     = (count_q == CNT_W'(1));
          end
        end
        default: out_load = 1'b0;
      endcase
    end else if (list_busy && slot_free) begin
      // remaining listed entries, head of the rotating chain for each result
      out_load   = 1'b1;
      ctrl.op    = OP_ROT;
      list_rem_d = list_rem_q - 1'b1;
      sts_d      = ST_LIST;
      val_d      = cell_entry[0].value;
      pri_d      = cell_entry[0].prio;
      last_d     = (list_rem_q == CNT_W'(1));
    end
  end

  // the chain: cell 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_ge;

    if (i == 0) begin : g_head
      assign prev_e  = '0;
      assign prev_ge = 1'b1;
    end else begin : g_body
      assign prev_e  = cell_entry[i-1];
      assign prev_ge = cell_ge[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .prev_i    (prev_e),
      .prev_ge_i (prev_ge),
      .next_i    (next_e),
      .head_i    (cell_entry[0]),
      .entry_o   (cell_entry[i]),
      .ge_o      (cell_ge[i])
    );
  end

  // result handshake
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      list_rem_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      list_rem_q  <= list_rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sts_q  <= sts_d;
      val_q  <= val_d;
      pri_q  <= pri_d;
      occ_q  <= OCC_W'(count_d);
      last_q <= last_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = sts_q;
  assign out_o.out_value    = val_q;
  assign out_o.out_priority = pri_q;
  assign out_o.occupancy    = occ_q;
  assign out_o.last         = last_q;

endmodule
`default_nettype wire

@@ rtl/core/spq_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue, bound to its top level.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [STS_W-1:0] out_status_i,
  input wire logic [OCC_W-1:0] out_occupancy_i,
  input wire logic             out_last_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_occupancy_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  // overflow only on a full queue
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == ST_OVF) |-> out_occupancy_i == OCC_W'(DEPTH))
    else $error("overflow reported on a queue that is not full");

  // underflow and empty report an empty queue and close the request
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((out_status_i == ST_UNF) || (out_status_i == ST_EMPTY))
      |-> (out_occupancy_i == '0) && out_last_i)
    else $error("empty status with entries held");

  // no new request while a list is still running
  a_list_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == ST_LIST) && !out_last_i
      |-> !in_ready_i)
    else $error("request taken in the middle of a list");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_status_i    (out_o.status),
  .out_occupancy_i (out_o.occupancy),
  .out_last_i      (out_o.last)
);
`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Checks the sorted priority queue against a shadow copy of its contents.
// Requests are sent over the request channel. Every accepted request updates
// the shadow queue and queues the replies it should produce. Every reply
// taken from the result channel is compared field by field with the oldest
// queued one. A directed part covers the empty and full queue, the extreme
// values and ties of priority, and the unused action code. Random traffic
// then runs with a slow receiver, with a slow sender, and with no stalls.
// ----------------------------------------------------------------------------
module testbench
  import spq_pkg::*;
();

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned RANDOM_ITEMS  = 32;

  // action code that the queue takes and drops without a reply
  localparam logic [ACT_W-1:0] ACT_IGNORED = 2'd3;

  localparam logic signed [PRI_W-1:0] PRI_MAX = 32'sh7fff_ffff;
  localparam logic signed [PRI_W-1:0] PRI_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    status_e                 status;
    logic signed [VAL_W-1:0] value;
    logic signed [PRI_W-1:0] prio;
    logic [OCC_W-1:0]        occupancy;
    logic                    last;
  } reply_t;

  logic clk_i;
  logic rst_ni;

  spq_in_if  req_if ();
  spq_out_if rsp_if ();

  sorted_priority_queue #(
    .DEPTH (DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // shadow copy of the queue, head at index zero
  logic signed [VAL_W-1:0] shadow_value [DEPTH];
  logic signed [PRI_W-1:0] shadow_prio  [DEPTH];
  int unsigned             shadow_count;

  reply_t      reply_q[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // shadow queue
  // ---------------------------------------------------------------------------

  task automatic push_reply(input status_e st, input logic signed [VAL_W-1:0] val,
                            input logic signed [PRI_W-1:0] pri, input logic is_last);
    reply_t r;
    r.status    = st;
    r.value     = val;
    r.prio      = pri;
    r.occupancy = shadow_count[OCC_W-1:0];
    r.last      = is_last;
    reply_q.push_back(r);
  endtask

  task automatic serve_request(input logic [ACT_W-1:0] act,
                               input logic signed [VAL_W-1:0] val,
                               input logic signed [PRI_W-1:0] pri);
    int unsigned slot;
    case (act)
      ACT_ENQ: begin
        if (shadow_count >= DEPTH) begin
          push_reply(ST_OVF, '0, '0, 1'b1);
        end else begin
          // new entry goes behind everything of greater or equal priority
          slot = shadow_count;
          while (slot > 0 && shadow_prio[slot-1] < pri) begin
            shadow_value[slot] = shadow_value[slot-1];
            shadow_prio[slot]  = shadow_prio[slot-1];
            slot--;
          end
          shadow_value[slot] = val;
          shadow_prio[slot]  = pri;
          shadow_count++;
          push_reply(ST_ENQ, '0, '0, 1'b1);
        end
      end
      ACT_DEQ: begin
        if (shadow_count == 0) begin
          push_reply(ST_UNF, '0, '0, 1'b1);
        end else begin
          val = shadow_value[0];
          pri = shadow_prio[0];
          for (int k = 1; k < shadow_count; k++) begin
            shadow_value[k-1] = shadow_value[k];
            shadow_prio[k-1]  = shadow_prio[k];
          end
          shadow_count--;
          push_reply(ST_DEQ, val, pri, 1'b1);
        end
      end
      ACT_LIST: begin
        if (shadow_count == 0) begin
          push_reply(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int k = 0; k < shadow_count; k++) begin
            push_reply(ST_LIST, shadow_value[k], shadow_prio[k], k + 1 == shadow_count);
          end
        end
      end
      default: begin
        // unused action code, dropped
      end
    endcase
  endtask

  // every accepted request updates the shadow queue
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      serve_request(req_if.action, req_if.item_value, req_if.item_priority);
    end
  end

  // ---------------------------------------------------------------------------
  // reply checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string field, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    reply_t r;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (reply_q.size() == 0) begin
        $error("status: expected no item, got %0d", rsp_if.status);
        mismatches++;
      end else begin
        r = reply_q.pop_front();
        check_field("status", r.status, rsp_if.status);
        check_field("out_value", r.value, rsp_if.out_value);
        check_field("out_priority", r.prio, rsp_if.out_priority);
        check_field("occupancy", r.occupancy, rsp_if.occupancy);
        check_field("last", r.last, rsp_if.last);
      end
    end
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // holds the request until it is taken; valid stays high into the next item unless the sender idles
  task automatic send_request(input logic [ACT_W-1:0] act,
                              input logic signed [VAL_W-1:0] val,
                              input logic signed [PRI_W-1:0] pri);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid         <= 1'b1;
    req_if.action        <= act;
    req_if.item_value    <= val;
    req_if.item_priority <= pri;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // stops sending and waits until every queued reply has come back
  task automatic settle_queue();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // small priorities half the time so that ties are common, plus full range and limits
  function automatic logic signed [PRI_W-1:0] random_priority();
    case ($urandom_range(3))
      0, 1:    return $signed($urandom_range(6)) - 3;
      2:       return $urandom;
      default: return $urandom_range(1) ? PRI_MAX : PRI_MIN;
    endcase
  endfunction

  // bursts of filling and draining so that both full and empty are reached
  task automatic run_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    bit          filling;
    sent    = 0;
    filling = 1'($urandom_range(1));
    while (sent < n_items) begin
      if ($urandom_range(11) == 0) filling = !filling;
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_request(ACT_IGNORED, $urandom, $urandom);
      end else begin
        if (pick < 12) send_request(ACT_LIST, $urandom, $urandom);
        else if (pick < (filling ? 72 : 32)) send_request(ACT_ENQ, $urandom, random_priority());
        else send_request(ACT_DEQ, $urandom, $urandom);
        sent++;
      end
    end
    settle_queue();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // underflow, empty list and the unused code on a fresh queue
  task automatic test_empty_queue();
    send_request(ACT_DEQ, VAL_MAX, PRI_MAX);
    send_request(ACT_LIST, VAL_MIN, PRI_MIN);
    send_request(ACT_IGNORED, VAL_MAX, PRI_MIN);
    settle_queue();
  endtask

  // extreme values and priorities, ties kept in arrival order
  task automatic test_extremes_and_ties();
    send_request(ACT_ENQ, VAL_MAX, PRI_MIN);
    send_request(ACT_ENQ, VAL_MIN, PRI_MAX);
    send_request(ACT_ENQ, -32'sd1, 32'sd0);
    send_request(ACT_ENQ, 32'sd0, 32'sd0);
    send_request(ACT_ENQ, 32'sd1, -32'sd1);
    send_request(ACT_LIST, '0, '0);
    send_request(ACT_DEQ, '0, '0);
    settle_queue();
  endtask

  // fill to the top, overflow, then a full-length list
  task automatic test_full_queue();
    repeat (DEPTH - shadow_count) send_request(ACT_ENQ, $urandom, random_priority());
    send_request(ACT_ENQ, VAL_MAX, PRI_MAX);
    send_request(ACT_LIST, '0, '0);
    settle_queue();
  endtask

  task automatic test_random_slow_receiver();
    send_idle_pct = 6;
    recv_idle_pct = 86;
    run_random_traffic(RANDOM_ITEMS);
  endtask

  task automatic test_random_slow_sender();
    send_idle_pct = 86;
    recv_idle_pct = 6;
    run_random_traffic(RANDOM_ITEMS);
  endtask

  task automatic test_random_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_traffic(RANDOM_ITEMS);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.action        = ACT_ENQ;
    req_if.item_value    = '0;
    req_if.item_priority = '0;
    rsp_if.ready         = 1'b0;
    shadow_count         = 0;
    mismatches           = 0;
    send_idle_pct        = 6;
    recv_idle_pct        = 86;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_extremes_and_ties();
    test_full_queue();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_random_full_rate();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/spq_pkg.sv
rtl/core/spq_if.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
rtl/core/spq_checker.sv
tb/testbench.sv
